FILE: src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types and constants for the lfu page replacement block
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int PAGE_W          = 32;
  localparam int CFG_W           = 5;
  localparam int CFG_RESET       = 16;
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int COUNT_LIMIT_DEF = 10000;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIT,
    ST_SCAN,
    ST_EVICT,
    ST_INS
  } lfu_state_t;

  // per-cell operation broadcast along the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CAP,
    CELL_PUSH_HIT,
    CELL_PUSH_ALL,
    CELL_PULL
  } cell_op_t;

endpackage

FILE: src/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell
// one slot of the recency chain: page, use count, valid and a match flag
// ----------------------------------------------------------------------------
module lfu_cell import lfu_pkg::*; #(
  parameter int CNT_W = 14,
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_op_t          op,
  input  logic [IDX_W-1:0]  victim_idx,
  input  logic [PAGE_W-1:0] cmp_page,
  input  logic [PAGE_W-1:0] prev_page,
  input  logic [CNT_W-1:0]  prev_cnt,
  input  logic              prev_vld,
  input  logic [PAGE_W-1:0] next_page,
  input  logic [CNT_W-1:0]  next_cnt,
  input  logic              next_vld,
  input  logic              hit_in,
  output logic [PAGE_W-1:0] page,
  output logic [CNT_W-1:0]  cnt,
  output logic              vld,
  output logic              match_now,
  output logic              match,
  output logic              hit_out
);

  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              vld_r, vld_nxt;
  logic              match_r, match_nxt;

  assign match_now = vld_r && (page_r == cmp_page);
  // some slot at or behind this one holds the hit page
  assign hit_out   = hit_in | match_r;

  always_comb begin
    page_nxt  = page_r;
    cnt_nxt   = cnt_r;
    vld_nxt   = vld_r;
    match_nxt = match_r;
    unique case (op)
      CELL_HOLD: begin
      end
      CELL_CAP: begin
        match_nxt = match_now;
      end
      CELL_PUSH_HIT: begin
        if (hit_out) begin
          page_nxt = prev_page;
          cnt_nxt  = prev_cnt;
          vld_nxt  = prev_vld;
        end
      end
      CELL_PUSH_ALL: begin
        page_nxt = prev_page;
        cnt_nxt  = prev_cnt;
        vld_nxt  = prev_vld;
      end
      CELL_PULL: begin
        if (IDX_W'(IDX) >= victim_idx) begin
          page_nxt = next_page;
          cnt_nxt  = next_cnt;
          vld_nxt  = next_vld;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      match_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign page  = page_r;
  assign cnt   = cnt_r;
  assign vld   = vld_r;
  assign match = match_r;

endmodule

FILE: src/lfu_min_tree.sv
// ----------------------------------------------------------------------------
// lfu_min_tree
// registered tree that finds the slot with the lowest count, rearmost on ties
// ----------------------------------------------------------------------------
module lfu_min_tree import lfu_pkg::*; #(
  parameter int N     = 16,
  parameter int CNT_W = 14,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [N-1:0]     leaf_vld,
  input  logic [CNT_W-1:0] leaf_cnt [N],
  output logic             root_vld,
  output logic [IDX_W-1:0] root_idx
);

  localparam int P     = 1 << IDX_W;
  localparam int INNER = P - 1;
  localparam int NODES = 2 * P - 1;

  logic             nd_vld [NODES];
  logic [CNT_W-1:0] nd_cnt [NODES];
  logic [IDX_W-1:0] nd_idx [NODES];

  // leaves, padded up to a power of two with empty slots
  for (genvar g = 0; g < P; g++) begin : g_leaf
    if (g < N) begin : g_real
      assign nd_vld[INNER+g] = leaf_vld[g];
      assign nd_cnt[INNER+g] = leaf_cnt[g];
      assign nd_idx[INNER+g] = IDX_W'(g);
    end else begin : g_pad
      assign nd_vld[INNER+g] = 1'b0;
      assign nd_cnt[INNER+g] = '0;
      assign nd_idx[INNER+g] = '0;
    end
  end

  // one register per level; left child holds the lower (more recent) slots
  for (genvar k = 0; k < INNER; k++) begin : g_node
    logic             v_r, v_nxt;
    logic [CNT_W-1:0] c_r, c_nxt;
    logic [IDX_W-1:0] i_r, i_nxt;
    logic             take_right;

    assign take_right = nd_vld[2*k+2] &&
                        (!nd_vld[2*k+1] || (nd_cnt[2*k+2] <= nd_cnt[2*k+1]));

    always_comb begin
      if (take_right) begin
        v_nxt = nd_vld[2*k+2];
        c_nxt = nd_cnt[2*k+2];
        i_nxt = nd_idx[2*k+2];
      end else begin
        v_nxt = nd_vld[2*k+1];
        c_nxt = nd_cnt[2*k+1];
        i_nxt = nd_idx[2*k+1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else begin
        v_r <= v_nxt;
      end
    end

    always_ff @(posedge clk) begin
      c_r <= c_nxt;
      i_r <= i_nxt;
    end

    assign nd_vld[k] = v_r;
    assign nd_cnt[k] = c_r;
    assign nd_idx[k] = i_r;
  end

  assign root_vld = nd_vld[0];
  assign root_idx = nd_idx[0];

endmodule

FILE: src/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement
// least-frequently-used page table with least-recent tie-break, built as a
// chain of slot cells plus a registered minimum-count tree
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake               payload
//  in_          in         start high, busy low    in_page_number [31:0]
//  out_         out        out_valid, one cycle    out_faulted_page [31:0]
//  cfg_         in         cfg_wr_en               cfg_wr_data [4:0]
//
// a hit does the tag compare on accept, then the chain shifts the page to
// the front. a miss without eviction inserts the page after the accept. each
// eviction waits in a scan while the registered min-count tree settles,
// then closes the gap at the victim slot.
// the fault beat leaves in the cycle after the accepting edge.
// synchronous active-low reset empties the table and loads the limit with 16;
// slot contents need no clearing pass. the receiver cannot stall results.
//
module lfu_page_replacement import lfu_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // reference channel
  input  logic              start,
  output logic              busy,
  input  logic [PAGE_W-1:0] in_page_number,
  // fault channel
  output logic              out_valid,
  output logic [PAGE_W-1:0] out_faulted_page,
  // limit register
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data
);

  localparam int CNT_W = $clog2(COUNT_LIMIT + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RES_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (RES_W > CFG_W) ? RES_W : CFG_W;
  localparam int SC_W  = $clog2(IDX_W + 1);

  // control registers
  lfu_state_t        state_r, state_nxt;
  logic [CFG_W-1:0]  lim_r;
  logic [RES_W-1:0]  resident_r, resident_nxt;
  logic [SC_W-1:0]   scan_r, scan_nxt;
  logic [PAGE_W-1:0] pg_r;
  logic              out_valid_r;
  logic [PAGE_W-1:0] out_page_r;

  // chain wiring
  cell_op_t          cell_op;
  logic [PAGE_W-1:0] c_page [MAX_ENTRIES];
  logic [CNT_W-1:0]  c_cnt  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] c_vld;
  logic [MAX_ENTRIES-1:0] c_match_now;
  logic [MAX_ENTRIES-1:0] c_match;
  logic [MAX_ENTRIES-1:0] c_hit;
  logic [PAGE_W-1:0] head_page;
  logic [CNT_W-1:0]  head_cnt;

  logic              root_vld;
  logic [IDX_W-1:0]  root_idx;

  logic              accept;
  logic              any_hit;
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  hit_cnt_inc;
  logic [CFG_W-1:0]  lim_eff;
  logic [RES_W-1:0]  resident_dec;
  logic              full_now;
  logic              full_after;

  assign accept  = start && !busy;
  assign any_hit = |c_match_now;

  // a limit of zero acts as one; anything above the table size acts as the table size
  assign lim_eff      = (lim_r == '0) ? CFG_W'(1) : lim_r;
  assign resident_dec = resident_r - RES_W'(1);
  assign full_now     = (CMP_W'(resident_r) >= CMP_W'(lim_eff)) ||
                        (resident_r >= RES_W'(MAX_ENTRIES));
  assign full_after   = (resident_r != '0) &&
                        ((CMP_W'(resident_dec) >= CMP_W'(lim_eff)) ||
                         (resident_dec >= RES_W'(MAX_ENTRIES)));

  // count of the hit slot; at most one slot matches
  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_cnt = hit_cnt | ({CNT_W{c_match[i]}} & c_cnt[i]);
    end
  end

  // saturating use count
  assign hit_cnt_inc = (hit_cnt < CNT_W'(COUNT_LIMIT)) ? hit_cnt + CNT_W'(1) : hit_cnt;

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= CFG_W'(CFG_RESET);
    end else if (cfg_wr_en) begin
      lim_r <= cfg_wr_data;
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      resident_r <= '0;
      scan_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      resident_r <= resident_nxt;
      scan_r     <= scan_nxt;
    end
  end

  // sequencer next state and chain control
  always_comb begin
    state_nxt    = state_r;
    resident_nxt = resident_r;
    scan_nxt     = scan_r;
    cell_op      = CELL_HOLD;
    head_page    = pg_r;
    head_cnt     = CNT_W'(1);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cell_op  = CELL_CAP;
          scan_nxt = '0;
          if (any_hit) begin
            state_nxt = ST_HIT;
          end else if (full_now) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_INS;
          end
        end
      end
      ST_HIT: begin
        // hit page moves to the front, slots ahead of it slide back one
        cell_op   = CELL_PUSH_HIT;
        head_cnt  = hit_cnt_inc;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        // let the min tree settle on the current table
        if (scan_r == SC_W'(IDX_W - 1)) begin
          state_nxt = ST_EVICT;
        end else begin
          scan_nxt = scan_r + SC_W'(1);
        end
      end
      ST_EVICT: begin
        // close the gap at the victim slot
        cell_op      = CELL_PULL;
        resident_nxt = resident_dec;
        scan_nxt     = '0;
        state_nxt    = full_after ? ST_SCAN : ST_INS;
      end
      ST_INS: begin
        // new page at the front with a count of one
        cell_op      = CELL_PUSH_ALL;
        resident_nxt = resident_r + RES_W'(1);
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // captured reference and fault beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept && !any_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pg_r       <= in_page_number;
      out_page_r <= in_page_number;
    end
  end

  // chain of slot cells, slot 0 most recent
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [PAGE_W-1:0] p_page, n_page;
    logic [CNT_W-1:0]  p_cnt, n_cnt;
    logic              p_vld, n_vld, h_in;

    if (g == 0) begin : g_head
      assign p_page = head_page;
      assign p_cnt  = head_cnt;
      assign p_vld  = 1'b1;
    end else begin : g_mid
      assign p_page = c_page[g-1];
      assign p_cnt  = c_cnt[g-1];
      assign p_vld  = c_vld[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign n_page = '0;
      assign n_cnt  = '0;
      assign n_vld  = 1'b0;
      assign h_in   = 1'b0;
    end else begin : g_body
      assign n_page = c_page[g+1];
      assign n_cnt  = c_cnt[g+1];
      assign n_vld  = c_vld[g+1];
      assign h_in   = c_hit[g+1];
    end

    lfu_cell #(
      .CNT_W (CNT_W),
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (cell_op),
      .victim_idx (root_idx),
      .cmp_page   (in_page_number),
      .prev_page  (p_page),
      .prev_cnt   (p_cnt),
      .prev_vld   (p_vld),
      .next_page  (n_page),
      .next_cnt   (n_cnt),
      .next_vld   (n_vld),
      .hit_in     (h_in),
      .page       (c_page[g]),
      .cnt        (c_cnt[g]),
      .vld        (c_vld[g]),
      .match_now  (c_match_now[g]),
      .match      (c_match[g]),
      .hit_out    (c_hit[g])
    );
  end

  lfu_min_tree #(
    .N     (MAX_ENTRIES),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_min_tree (
    .clk      (clk),
    .rst_n    (rst_n),
    .leaf_vld (c_vld),
    .leaf_cnt (c_cnt),
    .root_vld (root_vld),
    .root_idx (root_idx)
  );

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_faulted_page = out_page_r;

  // a fault beat only follows an accepted reference
  a_fault_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("fault beat without an accepted reference");

  // the table never holds two copies of a page
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(c_match))
    else $error("more than one slot matched");

  // eviction only with a valid victim from the tree
  a_evict_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVICT) |-> (root_vld && (RES_W'(root_idx) < resident_r)))
    else $error("eviction without a resident victim");

  // occupancy stays within the table
  a_resident_bound: assert property (@(posedge clk) disable iff (!rst_n)
    resident_r <= RES_W'(MAX_ENTRIES))
    else $error("resident count beyond table size");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for lfu_page_replacement: a scoreboard of predicted page
// faults, fed by a behavioral page table, checked against every fault beat
// ----------------------------------------------------------------------------
module tb import lfu_pkg::*; ();

  // table geometry as built by the default instance
  localparam int SLOTS        = MAX_ENTRIES_DEF;
  localparam int USE_LIMIT    = COUNT_LIMIT_DEF;
  // worst miss: sixteen evictions plus the insert
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_DIR      = 24;
  localparam int SAT_HITS     = 30;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 85;
  localparam int QUIET_PHASE  = 3;
  localparam int PAUSE_PHASE  = 5;

  // limit per random phase; the last one is drawn at random
  localparam int PHASE_LIMITS [NUM_PHASES] = '{16, 1, 31, 0, 5, 2, 9, 16, 0};

  typedef enum logic {
    ROW_REF,
    ROW_CFG
  } row_kind_t;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_FAULT,
    EXP_NONE
  } fault_exp_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [PAGE_W-1:0] value;
    fault_exp_t        how;
  } dir_row_t;

  // directed references: field extremes, hits, limit lowered while full,
  // limit of zero, limit above the table size
  dir_row_t dir_rows [NUM_DIR] = '{
    '{ROW_REF, 32'h0000_0000, EXP_FAULT},
    '{ROW_REF, 32'hFFFF_FFFF, EXP_FAULT},
    '{ROW_REF, 32'h0000_0000, EXP_NONE},
    '{ROW_REF, 32'hFFFF_FFFF, EXP_NONE},
    '{ROW_REF, 32'h8000_0000, EXP_FAULT},
    '{ROW_REF, 32'h7FFF_FFFF, EXP_FAULT},
    '{ROW_REF, 32'h5555_5555, EXP_FAULT},
    '{ROW_REF, 32'hAAAA_AAAA, EXP_FAULT},
    '{ROW_REF, 32'h0000_0000, EXP_NONE},
    '{ROW_CFG, 32'd3,         EXP_NONE},
    '{ROW_REF, 32'h0000_1234, EXP_MODEL},
    '{ROW_REF, 32'h0000_0000, EXP_MODEL},
    '{ROW_REF, 32'hFFFF_FFFF, EXP_MODEL},
    '{ROW_REF, 32'h8000_0000, EXP_MODEL},
    '{ROW_CFG, 32'd0,         EXP_NONE},
    '{ROW_REF, 32'h0000_0001, EXP_FAULT},
    '{ROW_REF, 32'h0000_0001, EXP_NONE},
    '{ROW_REF, 32'h0000_0002, EXP_FAULT},
    '{ROW_REF, 32'h0000_0001, EXP_FAULT},
    '{ROW_CFG, 32'd31,        EXP_NONE},
    '{ROW_REF, 32'h0000_0002, EXP_FAULT},
    '{ROW_REF, 32'h0000_0001, EXP_NONE},
    '{ROW_CFG, 32'd16,        EXP_NONE},
    '{ROW_REF, 32'hDEAD_BEEF, EXP_MODEL}
  };

  // dut ports, all inputs known from time zero
  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic              out_valid;
  logic [PAGE_W-1:0] out_faulted_page;
  logic              cfg_wr_en      = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data    = '0;

  // behavioral page table, slot 0 is the most recently placed page
  logic [PAGE_W-1:0] lfu_page [SLOTS];
  logic [13:0]       lfu_uses [SLOTS];
  int                lfu_resident = 0;
  logic [CFG_W-1:0]  lfu_limit    = CFG_W'(CFG_RESET);

  // faults still owed by the dut, oldest first
  logic [PAGE_W-1:0] expected_faults [$];
  int                err_count   = 0;
  int                cycle_count = 0;

  lfu_page_replacement dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_faulted_page (out_faulted_page),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // hard stop in case a beat never shows up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [PAGE_W-1:0] got,
                               input logic [PAGE_W-1:0] want);
    $display("mismatch at cycle %0d: %s, got %h expected %h", cycle_count, what, got, want);
    err_count++;
  endtask

  // one table reference: on a hit bump the count (saturating) and move the
  // page to the front; on a miss evict lowest count, oldest first among ties,
  // until there is room, then place the page at the front with a count of one
  task automatic predict_fault(input logic [PAGE_W-1:0] page, output bit faulted);
    int          i;
    int          hit_at;
    int          eff;
    int          victim;
    logic [13:0] least;
    logic [13:0] uses;
    hit_at = -1;
    for (i = 0; i < lfu_resident; i++) begin
      if (hit_at < 0 && lfu_page[i] == page) hit_at = i;
    end
    if (hit_at >= 0) begin
      uses = lfu_uses[hit_at];
      if (uses < USE_LIMIT) uses++;
      for (i = hit_at; i > 0; i--) begin
        lfu_page[i] = lfu_page[i-1];
        lfu_uses[i] = lfu_uses[i-1];
      end
      lfu_page[0] = page;
      lfu_uses[0] = uses;
      faulted     = 1'b0;
    end else begin
      // zero acts as one, anything past the table acts as the table size
      eff = (lfu_limit == 0) ? 1 : (lfu_limit > SLOTS) ? SLOTS : int'(lfu_limit);
      while (lfu_resident > 0 && lfu_resident >= eff) begin
        victim = 0;
        least  = lfu_uses[0];
        for (i = 0; i < lfu_resident; i++) begin
          if (lfu_uses[i] <= least) begin
            least  = lfu_uses[i];
            victim = i;
          end
        end
        for (i = victim; i + 1 < lfu_resident; i++) begin
          lfu_page[i] = lfu_page[i+1];
          lfu_uses[i] = lfu_uses[i+1];
        end
        lfu_resident--;
      end
      for (i = lfu_resident; i > 0; i--) begin
        lfu_page[i] = lfu_page[i-1];
        lfu_uses[i] = lfu_uses[i-1];
      end
      lfu_page[0] = page;
      lfu_uses[0] = 14'd1;
      lfu_resident++;
      faulted = 1'b1;
    end
  endtask

  // sender gap: holds start low; n sets the length of the gap
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // present one reference and hold it until the dut takes the beat; start
  // is left high so back-to-back beats never drop it within one step
  task automatic send_ref(input logic [PAGE_W-1:0] page, input fault_exp_t how);
    bit faulted;
    @(negedge clk);
    start          <= 1'b1;
    in_page_number <= page;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_fault(page, faulted);
    case (how)
      EXP_MODEL: begin
        if (faulted) expected_faults.push_back(page);
      end
      EXP_FAULT: expected_faults.push_back(page);
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    hold_off(1);
    while (expected_faults.size() != 0) @(posedge clk);
  endtask

  // limit writes only with the table quiet: a trailing hit or eviction chain
  // may still be running after the last fault beat, so sit out its latency
  task automatic write_limit(input logic [CFG_W-1:0] lim_val);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim_val;
    @(posedge clk);
    lfu_limit = lim_val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // fault beats are checked in order against the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_faults.size() == 0) begin
        note_mismatch("fault beat with none pending", out_faulted_page, '0);
      end else begin
        if (out_faulted_page !== expected_faults[0])
          note_mismatch("faulted_page", out_faulted_page, expected_faults[0]);
        void'(expected_faults.pop_front());
      end
    end
  end

  initial begin
    logic [PAGE_W-1:0] pool [32];
    logic [PAGE_W-1:0] page;
    logic [CFG_W-1:0]  lim_val;
    int                pool_size;
    int                r;
    int                p;
    int                n;
    int                k;

    // hold reset once, then release it
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (r = 0; r < NUM_DIR; r++) begin
      if (dir_rows[r].kind == ROW_CFG) write_limit(dir_rows[r].value[CFG_W-1:0]);
      else send_ref(dir_rows[r].value, dir_rows[r].how);
    end

    // count growth: hammer one page, then a lightly used page must lose the
    // eviction to it
    write_limit(5'd2);
    send_ref(32'h0BAD_F00D, EXP_MODEL);
    for (n = 0; n < SAT_HITS; n++) send_ref(32'h0BAD_F00D, EXP_MODEL);
    send_ref(32'h0000_B0B0, EXP_MODEL);
    for (n = 0; n < 10; n++) send_ref(32'h0000_B0B0, EXP_MODEL);
    send_ref(32'h0000_C0C0, EXP_MODEL);
    send_ref(32'h0000_B0B0, EXP_MODEL);
    send_ref(32'h0BAD_F00D, EXP_MODEL);

    // random phases, each under its own limit; a small page pool just above
    // the limit keeps hits, evictions and count ties frequent
    for (p = 0; p < NUM_PHASES; p++) begin
      lim_val = (p == NUM_PHASES - 1) ? CFG_W'($urandom_range(0, 31)) : CFG_W'(PHASE_LIMITS[p]);
      write_limit(lim_val);
      pool_size = ((lim_val == 0) ? 1 : (lim_val > SLOTS) ? SLOTS : int'(lim_val))
                  + $urandom_range(1, 6);
      for (k = 0; k < pool_size; k++) pool[k] = $urandom;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // one phase runs with no sender gaps at all
        if (p != QUIET_PHASE && $urandom_range(99) < 31) hold_off($urandom_range(1, 4));
        // once, the sender stops until every fault has come back
        if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(99) < 78) page = pool[$urandom_range(pool_size - 1)];
        else page = $urandom;
        send_ref(page, EXP_MODEL);
      end
    end

    // drain, let any trailing work settle, then judge
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
